[rtl/srws_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srws_pkg
// Types and constants shared by the sound register write sequencer files.
// ---------------------------------------------------------------------------
package srws_pkg;

  // request codes carried by req_type
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_LOAD  = 2'd2,
    REQ_INIT  = 2'd3
  } req_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_INIT,
    ST_TICK_CHK,
    ST_TICK_EMIT
  } state_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTING    = 1'd1;

  // configuration reset values
  localparam logic [7:0] MASTER_VOL_RST = 8'h77;
  localparam logic [7:0] ROUTING_RST    = 8'hFF;

  // master registers written on init
  localparam logic [7:0] REG_SOUND_CTRL = 8'h26;
  localparam logic [7:0] REG_MASTER_VOL = 8'h24;
  localparam logic [7:0] REG_ROUTING    = 8'h25;
  localparam logic [7:0] SOUND_CTRL_ON  = 8'h80;

  // init write slots
  localparam logic [2:0] INIT_SLOT_CTRL = 3'd0;
  localparam logic [2:0] INIT_SLOT_VOL  = 3'd1;
  localparam logic [2:0] INIT_SLOT_ROUT = 3'd2;

  // input item
  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  channel;
    logic [7:0]  start_frame;
    logic [7:0]  table_addr;
    logic [47:0] frame_word;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       last_write;
  } out_item_t;

  // first register address of each channel
  function automatic logic [7:0] chan_base(input logic [1:0] ch);
    logic [7:0] base;
    unique case (ch)
      2'd0:    base = 8'h10;
      2'd1:    base = 8'h16;
      2'd2:    base = 8'h1A;
      default: base = 8'h20;
    endcase
    return base;
  endfunction

  // index of the final register byte of each channel
  function automatic logic [2:0] chan_last_byte(input logic [1:0] ch);
    logic [2:0] last;
    unique case (ch)
      2'd0, 2'd2: last = 3'd4;
      default:    last = 3'd3;
    endcase
    return last;
  endfunction

  // highest channel that fires on a tick
  function automatic logic [1:0] last_fire_chan(input logic [3:0] fire);
    logic [1:0] ch;
    priority if (fire[3]) ch = 2'd3;
    else if (fire[2])     ch = 2'd2;
    else if (fire[1])     ch = 2'd1;
    else                  ch = 2'd0;
    return ch;
  endfunction

endpackage

[rtl/sound_register_write_sequencer_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sound_register_write_sequencer_unit
// Four-channel frame-store sequencer emitting sound register writes.
// ---------------------------------------------------------------------------
// tick: a check of each channel in turn, then one register write per cycle while
//   the result side does not stall (up to 18 writes)
// load and start: a subtract loop folds start_frame or table_addr into the
//   frame store, taking off FRAMES until the address fits
// init: a master register write per cycle unless stalled; one item at a time
// reset: synchronous, all channels stopped, config back to 0x77 and 0xFF,
//   frame store contents undefined until loaded
module sound_register_write_sequencer_unit #(
  parameter int unsigned FRAMES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  srws_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output srws_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [srws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata
);
  import srws_pkg::*;

  localparam int unsigned AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned WW = ((AW > 8) ? AW : 8) + 1;
  localparam logic [WW-1:0] FRAMES_W = WW'(FRAMES);
  localparam logic [AW:0]   FRAMES_P = (AW + 1)'(FRAMES);

  // registers
  state_t          state_r, state_nxt;
  in_item_t        item_r;
  logic [WW-1:0]   addr_r;
  logic [1:0]      ch_r;
  logic [2:0]      idx_r;
  logic [3:0]      fire_r;
  logic [3:0]      stopped_r;
  logic [AW-1:0]   pos_r   [4];
  logic [7:0]      delay_r [4];
  logic [7:0]      master_vol_r;
  logic [7:0]      routing_r;
  logic            out_valid_r;
  out_item_t       out_item_r;
  logic [47:0]     rd_data_r;
  logic [47:0]     frame_mem [FRAMES];

  // combinational controls
  logic            in_acc;
  logic            slot_free;
  logic            emit_en;
  out_item_t       emit_item;
  logic            addr_fits;
  logic            chan_done;
  logic [AW:0]     pos_inc;
  logic [AW-1:0]   pos_next;
  logic [3:0]      fire_now;
  logic [7:0]      frame_byte;
  logic [7:0]      frame_delay;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // shared datapath pieces
  assign addr_fits   = (addr_r < FRAMES_W);
  assign pos_inc     = {1'b0, pos_r[ch_r]} + (AW + 1)'(1);
  assign pos_next    = (pos_inc == FRAMES_P) ? '0 : pos_inc[AW-1:0];
  assign frame_byte  = rd_data_r[{idx_r, 3'b000} +: 8];
  assign frame_delay = rd_data_r[47:40];
  assign chan_done   = (idx_r == chan_last_byte(ch_r));

  // channels that will fire on a tick, each on its own state
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      fire_now[c] = !stopped_r[c] && (delay_r[c] == 8'd0);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (req_t'(in_item.req_type))
            REQ_TICK:            state_nxt = ST_TICK_CHK;
            REQ_START, REQ_LOAD: state_nxt = ST_REDUCE;
            REQ_INIT:            state_nxt = ST_INIT;
          endcase
        end
      end
      ST_REDUCE: begin
        if (addr_fits) state_nxt = ST_IDLE;
      end
      ST_INIT: begin
        if (slot_free && (idx_r == INIT_SLOT_ROUT)) state_nxt = ST_IDLE;
      end
      ST_TICK_CHK: begin
        if (fire_now[ch_r])   state_nxt = ST_TICK_EMIT;
        else if (ch_r == 2'd3) state_nxt = ST_IDLE;
      end
      ST_TICK_EMIT: begin
        if (slot_free && chan_done) begin
          state_nxt = (ch_r == 2'd3) ? ST_IDLE : ST_TICK_CHK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result item generation
  always_comb begin
    emit_en   = 1'b0;
    emit_item = '0;
    unique case (state_r)
      ST_INIT: begin
        emit_en = slot_free;
        unique case (idx_r)
          INIT_SLOT_CTRL: emit_item = '{REG_SOUND_CTRL, SOUND_CTRL_ON, 1'b0};
          INIT_SLOT_VOL:  emit_item = '{REG_MASTER_VOL, master_vol_r, 1'b0};
          default:        emit_item = '{REG_ROUTING, routing_r, 1'b1};
        endcase
      end
      ST_TICK_EMIT: begin
        emit_en              = slot_free;
        emit_item.reg_addr   = chan_base(ch_r) + {5'd0, idx_r};
        emit_item.reg_data   = frame_byte;
        emit_item.last_write = chan_done && (ch_r == last_fire_chan(fire_r));
      end
      default: begin
        emit_en   = 1'b0;
        emit_item = '0;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      stopped_r    <= '1;
      master_vol_r <= MASTER_VOL_RST;
      routing_r    <= ROUTING_RST;
      out_valid_r  <= 1'b0;
      ch_r         <= '0;
      idx_r        <= '0;
      fire_r       <= '0;
      for (int c = 0; c < 4; c++) begin
        pos_r[c]   <= '0;
        delay_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MASTER_VOL: master_vol_r <= cfg_wdata;
          default:        routing_r    <= cfg_wdata;
        endcase
      end

      // result register
      if (emit_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          ch_r   <= '0;
          idx_r  <= '0;
          fire_r <= fire_now;
          if (in_acc && (req_t'(in_item.req_type) == REQ_INIT)) begin
            stopped_r <= '1;
            for (int c = 0; c < 4; c++) begin
              pos_r[c] <= '0;
            end
          end
        end
        ST_REDUCE: begin
          // start takes effect once the address is folded
          if (addr_fits && (req_t'(item_r.req_type) == REQ_START)) begin
            pos_r[item_r.channel]     <= addr_r[AW-1:0];
            delay_r[item_r.channel]   <= '0;
            stopped_r[item_r.channel] <= 1'b0;
          end
        end
        ST_INIT: begin
          if (slot_free) idx_r <= idx_r + 3'd1;
        end
        ST_TICK_CHK: begin
          idx_r <= '0;
          if (!fire_now[ch_r]) begin
            if (!stopped_r[ch_r]) delay_r[ch_r] <= delay_r[ch_r] - 8'd1;
            ch_r <= ch_r + 2'd1;
          end
        end
        ST_TICK_EMIT: begin
          if (slot_free) begin
            if (chan_done) begin
              // reload delay, then stop or step to the next frame
              delay_r[ch_r] <= frame_delay;
              if (frame_delay == 8'd0) stopped_r[ch_r] <= 1'b1;
              else                     pos_r[ch_r]     <= pos_next;
              ch_r <= ch_r + 2'd1;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end
        default: begin
          ch_r <= '0;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_item;
      if (req_t'(in_item.req_type) == REQ_LOAD) begin
        addr_r <= WW'(in_item.table_addr);
      end else begin
        addr_r <= WW'(in_item.start_frame);
      end
    end else if ((state_r == ST_REDUCE) && !addr_fits) begin
      addr_r <= addr_r - FRAMES_W;
    end
    if (emit_en) out_item_r <= emit_item;
  end

  // frame store
  always_ff @(posedge clk) begin
    if ((state_r == ST_REDUCE) && addr_fits &&
        (req_t'(item_r.req_type) == REQ_LOAD)) begin
      frame_mem[addr_r[AW-1:0]] <= item_r.frame_word;
    end
    rd_data_r <= frame_mem[pos_r[ch_r]];
  end

endmodule

[rtl/srws_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srws_checker
// Port-level checks for the sound register write sequencer.
// ---------------------------------------------------------------------------
module srws_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input srws_pkg::out_item_t out_item
);
  import srws_pkg::*;

  // reset leaves the block ready with no pending item
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  // every accepted item stalls the input side in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block ready right after accepting an item");

  // register addresses stay in the sound register window
  a_addr_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.reg_addr >= 8'h10) && (out_item.reg_addr <= 8'h26))
    else $error("register address outside sound window");

  // more writes pending keeps the input side stalled
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.last_write |-> in_stall)
    else $error("input ready before final write of an item");

endmodule

bind sound_register_write_sequencer_unit srws_checker u_srws_checker (.*);

[bench/tb_sound_register_write_sequencer_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sound_register_write_sequencer_unit
// Self-checking bench for the four-channel sound register write sequencer.
// A directed table covers init, extremes, address wrap, restart and the
// full 18-write tick; random phases then load short frame runs, arm
// channels and tick through them under several mixer settings. Every
// register write is checked against an in-bench model of the channels.
// ---------------------------------------------------------------------------
module tb_sound_register_write_sequencer_unit;
  import srws_pkg::*;

  localparam int ITEMS_PER_PHASE = 42;
  localparam int SETTLE_CYCLES   = 30;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_CYCLES     = 160;
  localparam int STALL_LIMIT     = 2000;
  localparam int MAX_SHOWN       = 40;

  // first register and register count of each channel
  localparam logic [7:0] CH_FIRST_REG [4] = '{8'h10, 8'h16, 8'h1A, 8'h20};
  localparam int         CH_NREGS     [4] = '{5, 4, 5, 4};

  // one stimulus row, with hand-typed writes where they are obvious
  typedef struct packed {
    in_item_t        item;
    logic            typed;
    logic [2:0]      n_typed;
    out_item_t [4:0] typed_w;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MASTER_VOL;
  logic [7:0]           cfg_wdata = 8'h00;

  // channel model state
  logic [47:0] frame_mem    [256];
  bit          frame_loaded [256];
  logic [7:0]  ch_pos       [4];
  logic [7:0]  ch_delay     [4];
  bit          ch_stopped   [4];
  logic [7:0]  mix_vol = MASTER_VOL_RST;
  logic [7:0]  mix_route = ROUTING_RST;

  out_item_t step_writes [$];
  out_item_t exp_q [$];

  int errors = 0;
  int writes_checked = 0;
  int items_sent = 0;
  int req_count [4] = '{0, 0, 0, 0};
  int max_burst = 0;
  int mixer_settings = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  sound_register_write_sequencer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mismatch log, one line each
  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) begin
      $display("ERROR %0t: %s", $time, msg);
    end
  endtask

  function automatic out_item_t wr(input logic [7:0] addr, input logic [7:0] data,
                                   input logic last);
    out_item_t w;
    w.reg_addr   = addr;
    w.reg_data   = data;
    w.last_write = last;
    return w;
  endfunction

  function automatic stim_row_t mk(input req_t r, input logic [1:0] ch,
                                   input logic [7:0] sf, input logic [7:0] ta,
                                   input logic [47:0] w);
    stim_row_t row;
    row = '0;
    row.item.req_type    = r;
    row.item.channel     = ch;
    row.item.start_frame = sf;
    row.item.table_addr  = ta;
    row.item.frame_word  = w;
    return row;
  endfunction

  // short delays keep channels running, now and then a long one
  function automatic logic [7:0] rand_delay();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 3));
  endfunction

  // every field random, request type given
  function automatic stim_row_t rnd_row(input req_t r);
    logic [47:0] w;
    w[47:32] = 16'($urandom());
    w[31:0]  = 32'($urandom());
    return mk(r, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), w);
  endfunction

  // channel model: one item in, its register writes into step_writes
  task automatic seq_step(input in_item_t it);
    logic [47:0] f;
    out_item_t   w;
    step_writes.delete();
    case (req_t'(it.req_type))
      REQ_LOAD: begin
        frame_mem[it.table_addr]    = it.frame_word;
        frame_loaded[it.table_addr] = 1'b1;
      end
      REQ_START: begin
        ch_pos[it.channel]     = it.start_frame;
        ch_delay[it.channel]   = 8'd0;
        ch_stopped[it.channel] = 1'b0;
      end
      REQ_INIT: begin
        for (int c = 0; c < 4; c++) begin
          ch_stopped[c] = 1'b1;
          ch_pos[c]     = 8'd0;
        end
        step_writes.push_back(wr(REG_SOUND_CTRL, SOUND_CTRL_ON, 1'b0));
        step_writes.push_back(wr(REG_MASTER_VOL, mix_vol, 1'b0));
        step_writes.push_back(wr(REG_ROUTING, mix_route, 1'b0));
      end
      default: begin
        for (int c = 0; c < 4; c++) begin
          if (ch_stopped[c]) continue;
          if (ch_delay[c] != 8'd0) begin
            ch_delay[c] = ch_delay[c] - 8'd1;
            continue;
          end
          f = frame_mem[ch_pos[c]];
          for (int b = 0; b < CH_NREGS[c]; b++) begin
            step_writes.push_back(wr(CH_FIRST_REG[c] + 8'(b), f[8*b +: 8], 1'b0));
          end
          ch_delay[c] = f[47:40];
          if (ch_delay[c] == 8'd0) ch_stopped[c] = 1'b1;
          else ch_pos[c] = ch_pos[c] + 8'd1;
        end
      end
    endcase
    if (step_writes.size() > 0) begin
      w = step_writes.pop_back();
      w.last_write = 1'b1;
      step_writes.push_back(w);
    end
  endtask

  // offer one item, wait for it to be taken, queue its expected writes
  task automatic offer(input stim_row_t row);
    in_valid <= 1'b1;
    in_item  <= row.item;
    do @(posedge clk); while (in_stall);
    seq_step(row.item);
    if (row.typed) begin
      for (int k = 0; k < int'(row.n_typed); k++) exp_q.push_back(row.typed_w[k]);
    end else begin
      foreach (step_writes[k]) exp_q.push_back(step_writes[k]);
    end
    if (step_writes.size() > max_burst) max_burst = step_writes.size();
    items_sent++;
    req_count[row.item.req_type]++;
    // sender gap
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // a tick never fetches a frame that was never loaded: load it first
  task automatic send_tick(input stim_row_t row);
    stim_row_t fill;
    for (int c = 0; c < 4; c++) begin
      if (!ch_stopped[c] && ch_delay[c] == 8'd0 && !frame_loaded[ch_pos[c]]) begin
        fill = rnd_row(REQ_LOAD);
        fill.item.table_addr = ch_pos[c];
        fill.item.frame_word[47:40] = rand_delay();
        offer(fill);
      end
    end
    offer(row);
  endtask

  // mixer registers, written only with the block idle
  task automatic program_mixer(input logic [7:0] mv, input logic [7:0] rt);
    in_valid <= 1'b0;
    do @(posedge clk); while (exp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MASTER_VOL;
    cfg_wdata <= mv;
    @(posedge clk);
    cfg_index <= CFG_ROUTING;
    cfg_wdata <= rt;
    @(posedge clk);
    cfg_we <= 1'b0;
    mix_vol   = mv;
    mix_route = rt;
    mixer_settings++;
  endtask

  // result side: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // compare each accepted write with the oldest expectation
  always @(posedge clk) begin : write_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      writes_checked++;
      if (exp_q.size() == 0) begin
        report($sformatf("unexpected write %02h <= %02h last %0b",
                         out_item.reg_addr, out_item.reg_data, out_item.last_write));
      end else begin
        want = exp_q.pop_front();
        if (out_item.reg_addr !== want.reg_addr)
          report($sformatf("reg_addr %02h, expected %02h", out_item.reg_addr,
                           want.reg_addr));
        if (out_item.reg_data !== want.reg_data)
          report($sformatf("reg_data %02h at %02h, expected %02h", out_item.reg_data,
                           want.reg_addr, want.reg_data));
        if (out_item.last_write !== want.last_write)
          report($sformatf("last_write %0b at %02h, expected %0b", out_item.last_write,
                           want.reg_addr, want.last_write));
      end
    end
  end

  // watchdog on handshake activity
  initial begin : watchdog
    int dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) dead_cycles = 0;
      else dead_cycles++;
    end
    $display("timeout: no item moved for %0d cycles, %0d writes outstanding",
             STALL_LIMIT, exp_q.size());
    $display("FAIL sound_register_write_sequencer_unit");
    $finish;
  end

  initial begin : stimulus
    stim_row_t  row;
    stim_row_t  dir_q [$];
    logic [7:0] base;
    logic [7:0] mv_set [4];
    logic [7:0] rt_set [4];
    int         n_frames;
    int         ph_start;
    bit         paused;

    paused = 1'b0;
    for (int c = 0; c < 4; c++) begin
      ch_pos[c]     = 8'd0;
      ch_delay[c]   = 8'd0;
      ch_stopped[c] = 1'b1;
    end
    foreach (frame_loaded[a]) frame_loaded[a] = 1'b0;

    // directed table
    // init straight after reset: master registers at reset values
    row = mk(REQ_INIT, 2'd3, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF);
    row.typed = 1'b1;
    row.n_typed = 3'd3;
    row.typed_w[0] = wr(REG_SOUND_CTRL, SOUND_CTRL_ON, 1'b0);
    row.typed_w[1] = wr(REG_MASTER_VOL, MASTER_VOL_RST, 1'b0);
    row.typed_w[2] = wr(REG_ROUTING, ROUTING_RST, 1'b1);
    dir_q.push_back(row);
    // tick with every channel stopped gives nothing
    row = mk(REQ_TICK, 2'd0, 8'h00, 8'h00, 48'h0);
    row.typed = 1'b1;
    dir_q.push_back(row);
    // channel 0, one frame with zero delay, then stopped
    dir_q.push_back(mk(REQ_LOAD, 2'd0, 8'h00, 8'h00, 48'h00_55_44_33_22_11));
    dir_q.push_back(mk(REQ_START, 2'd0, 8'h00, 8'h00, 48'h0));
    row = mk(REQ_TICK, 2'd0, 8'h00, 8'h00, 48'h0);
    row.typed = 1'b1;
    row.n_typed = 3'd5;
    row.typed_w[0] = wr(8'h10, 8'h11, 1'b0);
    row.typed_w[1] = wr(8'h11, 8'h22, 1'b0);
    row.typed_w[2] = wr(8'h12, 8'h33, 1'b0);
    row.typed_w[3] = wr(8'h13, 8'h44, 1'b0);
    row.typed_w[4] = wr(8'h14, 8'h55, 1'b1);
    dir_q.push_back(row);
    // channel 1 from the top frame, delay one, wraps round to frame 0
    dir_q.push_back(mk(REQ_LOAD, 2'd0, 8'h00, 8'hFF, 48'h01_A5_5A_C3_3C_96));
    dir_q.push_back(mk(REQ_START, 2'd1, 8'hFF, 8'h00, 48'h0));
    dir_q.push_back(mk(REQ_TICK, 2'd0, 8'h00, 8'h00, 48'h0));
    dir_q.push_back(mk(REQ_TICK, 2'd0, 8'h00, 8'h00, 48'h0));
    dir_q.push_back(mk(REQ_TICK, 2'd0, 8'h00, 8'h00, 48'h0));
    // all-ones and all-zeros frames on channels 2 and 3
    dir_q.push_back(mk(REQ_LOAD, 2'd0, 8'h00, 8'hAA, 48'hFFFF_FFFF_FFFF));
    dir_q.push_back(mk(REQ_LOAD, 2'd0, 8'h00, 8'h55, 48'h0));
    dir_q.push_back(mk(REQ_START, 2'd2, 8'h55, 8'h00, 48'h0));
    dir_q.push_back(mk(REQ_TICK, 2'd0, 8'h00, 8'h00, 48'h0));
    dir_q.push_back(mk(REQ_START, 2'd3, 8'hAA, 8'h00, 48'h0));
    dir_q.push_back(mk(REQ_TICK, 2'd0, 8'h00, 8'h00, 48'h0));
    // restart of channel 3 while it waits out a long delay
    dir_q.push_back(mk(REQ_START, 2'd3, 8'h00, 8'h00, 48'h0));
    dir_q.push_back(mk(REQ_TICK, 2'd0, 8'h00, 8'h00, 48'h0));
    // all four channels on one frame: the longest burst
    dir_q.push_back(mk(REQ_LOAD, 2'd0, 8'h00, 8'h10, 48'h02_F0_E1_D2_C3_B4));
    for (int c = 0; c < 4; c++) dir_q.push_back(mk(REQ_START, 2'(c), 8'h10, 8'h00, 48'h0));
    dir_q.push_back(mk(REQ_TICK, 2'd0, 8'h00, 8'h00, 48'h0));
    // init halts running channels
    row = mk(REQ_INIT, 2'd0, 8'h00, 8'h00, 48'h0);
    row.typed = 1'b1;
    row.n_typed = 3'd3;
    row.typed_w[0] = wr(REG_SOUND_CTRL, SOUND_CTRL_ON, 1'b0);
    row.typed_w[1] = wr(REG_MASTER_VOL, MASTER_VOL_RST, 1'b0);
    row.typed_w[2] = wr(REG_ROUTING, ROUTING_RST, 1'b1);
    dir_q.push_back(row);
    dir_q.push_back(mk(REQ_TICK, 2'd0, 8'h00, 8'h00, 48'h0));

    mv_set = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), 8'h5A};
    rt_set = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), 8'hA5};

    // reset
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_q[i]) offer(dir_q[i]);

    // random phases, one mixer setting each, last phase without idling
    for (int ph = 0; ph < 4; ph++) begin
      program_mixer(mv_set[ph], rt_set[ph]);
      quiet = (ph == 3);
      ph_start = items_sent;
      while (items_sent - ph_start < ITEMS_PER_PHASE) begin
        // long result hold-off while items keep coming
        if (ph == 1 && !hold_req && items_sent - ph_start > 8) hold_req = 1'b1;
        // sender waits for every outstanding write
        if (ph == 2 && !paused && items_sent - ph_start > 25) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (exp_q.size() != 0);
          paused = 1'b1;
        end
        if ($urandom_range(0, 3) != 0) begin
          // a short frame run: load, arm channels, tick through it
          base = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 15));
          n_frames = $urandom_range(1, 4);
          for (int k = 0; k < n_frames; k++) begin
            row = rnd_row(REQ_LOAD);
            row.item.table_addr = base + 8'(k);
            row.item.frame_word[47:40] =
              (k == n_frames - 1 && $urandom_range(0, 1) == 0) ? 8'd0 : rand_delay();
            offer(row);
          end
          repeat ($urandom_range(1, 3)) begin
            row = rnd_row(REQ_START);
            row.item.start_frame = base + 8'($urandom_range(0, n_frames - 1));
            offer(row);
          end
          repeat ($urandom_range(2, 10)) send_tick(rnd_row(REQ_TICK));
        end else begin
          // noise: any request, any field values
          row = rnd_row(req_t'($urandom_range(0, 3)));
          if (req_t'(row.item.req_type) == REQ_TICK) send_tick(row);
          else offer(row);
        end
      end
      offer(rnd_row(REQ_INIT));
    end

    // drain
    in_valid <= 1'b0;
    do @(posedge clk); while (exp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (exp_q.size() != 0) report($sformatf("%0d expected writes never came", exp_q.size()));

    $display("covered %0d items: %0d ticks, %0d starts, %0d loads, %0d inits",
             items_sent, req_count[REQ_TICK], req_count[REQ_START],
             req_count[REQ_LOAD], req_count[REQ_INIT]);
    $display("%0d register writes checked, longest burst %0d, %0d mixer settings",
             writes_checked, max_burst, mixer_settings);
    if (errors == 0) begin
      $display("PASS sound_register_write_sequencer_unit");
    end else begin
      $display("FAIL sound_register_write_sequencer_unit");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/srws_pkg.sv
rtl/sound_register_write_sequencer_unit.sv
rtl/srws_checker.sv
bench/tb_sound_register_write_sequencer_unit.sv
